### hdl/assert_macros.svh
// Assertion macros shared by the RTL of the block allocator.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk_sig, rst_n_sig, ante, cons) \
	lbl: assert property (@(posedge clk_sig) disable iff (!(rst_n_sig)) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk_sig, rst_n_sig, ante, cons) \
	lbl: assert property (@(posedge clk_sig) disable iff (!(rst_n_sig)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk_sig, rst_n_sig, ante, cons)
`define ASSERT_NEXT(lbl, clk_sig, rst_n_sig, ante, cons)
`endif

`endif

### hdl/fba_pkg.sv
// Types, command codes and constants of the flash block allocator.
// Depends on nothing; used by the top level and its port list.
package fba_pkg;

	localparam int BLOCK_COUNT_DEF     = 1024;
	localparam int PROTECTED_COUNT_DEF = 2;

	localparam logic [3:0] FRESH_AGE = 4'b1100;
	localparam logic [3:0] AGE_MAX   = 4'hF;
	localparam logic [7:0] AGE_MASK  = 8'b00001111;
	localparam logic [4:0] LEVEL_TOP = 5'd16;

	localparam logic [2:0] CMD_ALLOC     = 3'd0;
	localparam logic [2:0] CMD_FREE      = 3'd1;
	localparam logic [2:0] CMD_PROTECT   = 3'd2;
	localparam logic [2:0] CMD_LOAD      = 3'd3;
	localparam logic [2:0] CMD_SET_COUNT = 3'd4;
	localparam logic [2:0] CMD_READ      = 3'd5;

	typedef struct packed {
		logic [2:0]  command;
		logic [9:0]  block_index;
		logic [3:0]  ftype;
		logic [7:0]  entry_value;
		logic [10:0] count_value;
	} fba_cmd_t;

	typedef struct packed {
		logic [9:0]  result_block;
		logic [7:0]  result_entry;
		logic        reused;
		logic        status;
		logic [10:0] used_cnt;
	} fba_rsp_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_MODIFY,
		ST_SCAN,
		ST_AGE,
		ST_ALLOC_WR,
		ST_LEVEL,
		ST_DONE
	} fba_state_t;

endpackage

### hdl/flash_block_allocator_aging_top.sv
// Flash block allocator: one byte per block (type nibble, age nibble) in a
// synchronous table memory, with a used-block count beside it.
// Depends on fba_pkg and assert_macros.svh.
//
// Free, protect, load, set count and read pass through a read state and a modify state,
// in which the response word is registered once the output is free; the next command is
// accepted only after the return to idle. Allocate scans one entry a cycle until a free
// entry or the last one, then may run one or two aging passes through the single table
// port pair before the response.
// After reset the table is cleared entry by entry while cmd_stall stays high.
`include "assert_macros.svh"

module flash_block_allocator_aging_top #(
	parameter int BLOCK_COUNT     = fba_pkg::BLOCK_COUNT_DEF,
	parameter int PROTECTED_COUNT = fba_pkg::PROTECTED_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  fba_pkg::fba_cmd_t cmd,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output fba_pkg::fba_rsp_t rsp
);
	import fba_pkg::*;

	localparam int IW = $clog2(BLOCK_COUNT);
	localparam int CW = $clog2(BLOCK_COUNT + 1);
	localparam int TW = CW + 5;
	localparam logic [CW-1:0] BC   = CW'(BLOCK_COUNT);
	localparam logic [CW-1:0] LAST = CW'(BLOCK_COUNT - 1);
	localparam logic [CW-1:0] PROT = CW'(PROTECTED_COUNT);

	fba_state_t state_q, state_d;

	fba_cmd_t item_q;
	fba_rsp_t rsp_q, rsp_d;
	logic     out_valid_q;

	logic [CW-1:0] addr_q, addr_s1;
	logic          vld_s1;
	logic [7:0]    rd_data_q;

	logic [IW-1:0] blk_q;
	logic [3:0]    oldest_age_q;
	logic          found_q, pass2_q, aged_q;
	logic [3:0]    anchor_q;
	logic [CW-1:0] used_q;

	logic [7:0] mem [BLOCK_COUNT];

	// Memory port controls.
	logic          mem_we, rd_en, rd_issue;
	logic [IW-1:0] mem_wa, rd_addr;
	logic [7:0]    mem_wd;

	logic accept, out_free, out_load;

	// Datapath terms.
	logic [IW-1:0] idx_addr;
	logic          in_range, prot_ok;
	logic [3:0]    scan_age;
	logic          scan_zero, scan_last, scan_better;
	logic [IW-1:0] oldest_nx;
	logic [3:0]    oldest_age_nx;
	logic [7:0]    aged_byte, fresh;
	logic [TW-1:0] level_lhs, level_rhs;
	logic          level_age;
	logic [7:0]    new_byte;
	logic          do_write, status_nx;
	logic [CW-1:0] used_nx;

	assign accept   = cmd_valid && !cmd_stall;
	assign out_free = !out_valid_q || !rsp_stall;
	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		idx_addr  = IW'(item_q.block_index);
		in_range  = {22'd0, item_q.block_index} < 32'(BLOCK_COUNT);
		prot_ok   = {22'd0, item_q.block_index} >= 32'(PROTECTED_COUNT);
		fresh     = {item_q.ftype, FRESH_AGE};

		scan_age      = rd_data_q[3:0];
		scan_zero     = vld_s1 && (rd_data_q == 8'd0);
		scan_last     = vld_s1 && (addr_s1 == LAST);
		scan_better   = vld_s1 && (scan_age < oldest_age_q);
		oldest_nx     = scan_better ? addr_s1[IW-1:0] : blk_q;
		oldest_age_nx = scan_better ? scan_age : oldest_age_q;

		aged_byte = rd_data_q;
		if ((scan_age != 4'd0) && (scan_age != AGE_MAX)) begin
			aged_byte = rd_data_q - 8'd1;
		end

		// level < anchor  <=>  16 * used >= (17 - anchor) * BLOCK_COUNT
		level_lhs = TW'({used_q, 4'b0000});
		level_rhs = TW'(LEVEL_TOP + 5'd1 - {1'b0, anchor_q}) * TW'(BLOCK_COUNT);
		level_age = level_lhs >= level_rhs;

		new_byte  = rd_data_q;
		do_write  = 1'b0;
		status_nx = 1'b0;
		used_nx   = used_q;
		if (item_q.command == CMD_SET_COUNT) begin
			if ({21'd0, item_q.count_value} > 32'(BLOCK_COUNT)) begin
				used_nx = BC;
			end else begin
				used_nx = CW'(item_q.count_value);
			end
		end else if (in_range) begin
			priority if (item_q.command == CMD_FREE) begin
				if (prot_ok) begin
					new_byte = 8'd0;
					do_write = 1'b1;
					if (used_q != '0) begin
						used_nx = used_q - CW'(1);
					end
				end else begin
					status_nx = 1'b1;
				end
			end else if (item_q.command == CMD_PROTECT) begin
				new_byte = rd_data_q | AGE_MASK;
				do_write = 1'b1;
			end else if (item_q.command == CMD_LOAD) begin
				new_byte = item_q.entry_value;
				do_write = 1'b1;
			end else begin
				new_byte = rd_data_q;
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (addr_q == LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = (cmd.command == CMD_ALLOC) ? ST_SCAN : ST_READ;
				end
			end
			ST_READ: state_d = ST_MODIFY;
			ST_MODIFY: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (scan_zero) begin
					state_d = ST_ALLOC_WR;
				end else if (scan_last) begin
					state_d = (oldest_age_nx != 4'd0) ? ST_AGE : ST_ALLOC_WR;
				end
			end
			ST_AGE: begin
				if (scan_last) begin
					state_d = pass2_q ? ST_DONE : ST_ALLOC_WR;
				end
			end
			ST_ALLOC_WR: state_d = ST_LEVEL;
			ST_LEVEL: state_d = level_age ? ST_AGE : ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory port and response controls.
	always_comb begin
		cmd_stall = (state_q != ST_IDLE);
		rd_en     = 1'b0;
		rd_issue  = 1'b0;
		rd_addr   = addr_q[IW-1:0];
		mem_we    = 1'b0;
		mem_wa    = addr_s1[IW-1:0];
		mem_wd    = aged_byte;
		out_load  = 1'b0;
		rsp_d     = rsp_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = addr_q[IW-1:0];
				mem_wd = 8'd0;
			end
			ST_READ: begin
				rd_en   = 1'b1;
				rd_addr = idx_addr;
			end
			ST_MODIFY: begin
				out_load = out_free;
				mem_we   = out_free && do_write;
				mem_wa   = idx_addr;
				mem_wd   = new_byte;
				rsp_d.result_block = item_q.block_index;
				rsp_d.result_entry = in_range ? new_byte : 8'd0;
				rsp_d.reused       = 1'b0;
				rsp_d.status       = status_nx;
				rsp_d.used_cnt     = 11'(used_nx);
			end
			ST_SCAN: begin
				rd_issue = (addr_q < BC) && !scan_zero;
				rd_en    = rd_issue;
			end
			ST_AGE: begin
				rd_issue = (addr_q < BC);
				rd_en    = rd_issue;
				mem_we   = vld_s1;
			end
			ST_ALLOC_WR: begin
				mem_we = 1'b1;
				mem_wa = blk_q;
				mem_wd = fresh;
			end
			ST_DONE: begin
				out_load = out_free;
				// A level-driven pass after the write ages the fresh entry too.
				rsp_d.result_block = 10'(blk_q);
				rsp_d.result_entry = fresh - {7'd0, aged_q};
				rsp_d.reused       = !found_q;
				rsp_d.status       = 1'b0;
				rsp_d.used_cnt     = 11'(used_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			addr_q      <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			used_q      <= '0;
			anchor_q    <= 4'd0;
		end else begin
			state_q <= state_d;
			vld_s1  <= rd_issue;

			if (state_q == ST_CLEAR) begin
				addr_q <= addr_q + CW'(1);
			end else if ((state_d == ST_SCAN) && (state_q != ST_SCAN)) begin
				addr_q <= PROT;
			end else if ((state_d == ST_AGE) && (state_q != ST_AGE)) begin
				addr_q <= '0;
			end else if (rd_issue) begin
				addr_q <= addr_q + CW'(1);
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end

			if ((state_q == ST_MODIFY) && out_free) begin
				used_q <= used_nx;
			end else if ((state_q == ST_ALLOC_WR) && found_q && (used_q != BC)) begin
				used_q <= used_q + CW'(1);
			end

			// Shadow of the age nibble of entry 0, the anchor of the level check.
			if ((state_d == ST_AGE) && (state_q != ST_AGE)) begin
				if ((anchor_q != 4'd0) && (anchor_q != AGE_MAX)) begin
					anchor_q <= anchor_q - 4'd1;
				end
			end else if ((state_q == ST_MODIFY) && out_free && in_range &&
					(item_q.block_index == 10'd0)) begin
				if (item_q.command == CMD_PROTECT) begin
					anchor_q <= AGE_MAX;
				end else if (item_q.command == CMD_LOAD) begin
					anchor_q <= item_q.entry_value[3:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr_q;
		if (accept) begin
			item_q       <= cmd;
			blk_q        <= IW'(PROTECTED_COUNT);
			oldest_age_q <= AGE_MAX;
			found_q      <= 1'b0;
			pass2_q      <= 1'b0;
			aged_q       <= 1'b0;
		end else if ((state_q == ST_SCAN) && vld_s1) begin
			if (scan_zero) begin
				blk_q   <= addr_s1[IW-1:0];
				found_q <= 1'b1;
			end else begin
				blk_q        <= oldest_nx;
				oldest_age_q <= oldest_age_nx;
			end
		end else if ((state_q == ST_LEVEL) && level_age) begin
			pass2_q <= 1'b1;
			aged_q  <= 1'b1;
		end
		if (out_load) begin
			rsp_q <= rsp_d;
		end
	end

	`ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, accept, state_q != ST_IDLE)
	`ASSERT_IMPL(a_no_overwrite, clk, arst_n, out_load, out_free)
	`ASSERT_IMPL(a_rsp_source, clk, arst_n, $rose(rsp_valid), $past(out_load))
	`ASSERT_IMPL(a_used_bound, clk, arst_n, state_q != ST_CLEAR, used_q <= BC)

endmodule

### bench/tb.sv
// Self-checking bench for the flash block allocator with aging.
// Depends on fba_pkg and flash_block_allocator_aging_top; it predicts every response
// word from its own copy of the block table and the used-block count.
`timescale 1ns / 1ps

module tb;
	import fba_pkg::*;

	localparam int BLOCKS      = BLOCK_COUNT_DEF;
	localparam int PROTECTED   = PROTECTED_COUNT_DEF;
	localparam int HOLD_CYCLES = 200;
	localparam int QUIET_LIMIT = 20000;

	// The two spare command codes decode as reads.
	localparam logic [2:0] CMD_SPARE_A = 3'd6;
	localparam logic [2:0] CMD_SPARE_B = 3'd7;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     cmd_valid = 1'b0;
	logic     cmd_stall;
	fba_cmd_t cmd       = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	fba_rsp_t rsp;

	fba_cmd_t   cmd_words[$];
	fba_rsp_t   expected_rsp_words[$];
	fba_rsp_t   predicted_word;
	fba_rsp_t   checked_word;
	logic [7:0] block_bytes [BLOCKS] = '{default: 8'h00};
	int         used_total = 0;
	idle_mode_t idle_mode = IDLE_NONE;
	int         mismatches = 0;
	int         hold_requests = 0;
	int         holds_started;
	int         hold_left;
	int         quiet_cycles;

	flash_block_allocator_aging_top #(
		.BLOCK_COUNT(BLOCKS),
		.PROTECTED_COUNT(PROTECTED)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic age_all_blocks();
		for (int i = 0; i < BLOCKS; i++) begin
			if (block_bytes[i][3:0] != 4'd0 && block_bytes[i][3:0] != AGE_MAX)
				block_bytes[i] = block_bytes[i] - 8'd1;
		end
	endtask

	task automatic predict_response(input fba_cmd_t c, output fba_rsp_t r);
		logic [7:0] fresh;
		logic [3:0] low_age;
		int blk;
		int oldest;
		int level;
		bit found;
		r = '0;
		blk = c.block_index;
		if (c.command == CMD_ALLOC) begin
			fresh = {c.ftype, FRESH_AGE};
			oldest = PROTECTED;
			low_age = AGE_MAX;
			found = 1'b0;
			for (int i = PROTECTED; i < BLOCKS && !found; i++) begin
				if (block_bytes[i] == 8'h00) begin
					found = 1'b1;
					blk = i;
				end else if (block_bytes[i][3:0] < low_age) begin
					oldest = i;
					low_age = block_bytes[i][3:0];
				end
			end
			if (found) begin
				if (used_total < BLOCKS)
					used_total++;
			end else begin
				// Full table: reclaim the oldest block, aging everything first
				// unless the oldest one is already at age zero.
				if (low_age != 4'd0)
					age_all_blocks();
				blk = oldest;
				r.reused = 1'b1;
			end
			block_bytes[blk] = fresh;
			level = int'(LEVEL_TOP) - (used_total * 16) / BLOCKS;
			if (level < int'(block_bytes[0][3:0]))
				age_all_blocks();
			r.result_entry = block_bytes[blk];
		end else if (c.command == CMD_SET_COUNT) begin
			used_total = (c.count_value > BLOCKS) ? BLOCKS : int'(c.count_value);
			if (blk < BLOCKS)
				r.result_entry = block_bytes[blk];
		end else if (blk < BLOCKS) begin
			case (c.command)
				CMD_FREE: begin
					if (blk >= PROTECTED) begin
						block_bytes[blk] = 8'h00;
						if (used_total > 0)
							used_total--;
					end else begin
						r.status = 1'b1;
					end
				end
				CMD_PROTECT: begin
					block_bytes[blk] = block_bytes[blk] | AGE_MASK;
				end
				CMD_LOAD: begin
					block_bytes[blk] = c.entry_value;
				end
				default: begin
				end
			endcase
			r.result_entry = block_bytes[blk];
		end
		r.result_block = blk[9:0];
		r.used_cnt = used_total[10:0];
	endtask

	function automatic bit idle_now(input bit receiver_side);
		case (idle_mode)
			IDLE_SENDER:   return !receiver_side && $urandom_range(99) < 51;
			IDLE_RECEIVER: return receiver_side && $urandom_range(99) < 51;
			IDLE_BOTH:     return $urandom_range(99) < 28;
			default:       return 1'b0;
		endcase
	endfunction

	// Driver: a word stays on the bus until it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd <= '0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				predict_response(cmd, predicted_word);
				expected_rsp_words.push_back(predicted_word);
			end
			if (!cmd_valid || !cmd_stall) begin
				if (cmd_words.size() != 0 && !idle_now(1'b0)) begin
					cmd <= cmd_words.pop_front();
					cmd_valid <= 1'b1;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t ns: %s expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Monitor: checks response words and drives the stall, including long hold-offs.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			hold_left <= 0;
			holds_started <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp_words.size() == 0) begin
					$display("%0t ns: response word expected none, actual %0h", $time, rsp);
					mismatches++;
				end else begin
					checked_word = expected_rsp_words.pop_front();
					check_field("result_block", checked_word.result_block, rsp.result_block);
					check_field("result_entry", checked_word.result_entry, rsp.result_entry);
					check_field("reused", checked_word.reused, rsp.reused);
					check_field("status", checked_word.status, rsp.status);
					check_field("used_cnt", checked_word.used_cnt, rsp.used_cnt);
				end
			end
			if (holds_started != hold_requests) begin
				holds_started <= holds_started + 1;
				hold_left <= HOLD_CYCLES;
				rsp_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= idle_now(1'b1);
			end
		end
	end

	// Watchdog on cycles in which neither side moves a word.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end else begin
			quiet_cycles <= 0;
		end
	end

	task automatic push_cmd(input logic [2:0] op, input logic [9:0] idx,
		input logic [3:0] ftype, input logic [7:0] value, input logic [10:0] count);
		fba_cmd_t c;
		c.command = op;
		c.block_index = idx;
		c.ftype = ftype;
		c.entry_value = value;
		c.count_value = count;
		cmd_words.push_back(c);
	endtask

	function automatic fba_cmd_t random_command();
		fba_cmd_t c;
		int pick;
		c.ftype = 4'($urandom_range(15));
		c.entry_value = ($urandom_range(99) < 15) ? 8'h00 : 8'($urandom_range(255));
		c.count_value = ($urandom_range(99) < 10) ? 11'($urandom_range(2047))
			: 11'($urandom_range(BLOCKS));
		pick = $urandom_range(99);
		c.block_index = (pick < 6) ? 10'($urandom_range(1))
			: (pick < 10) ? 10'd1023 : 10'($urandom_range(1023));
		pick = $urandom_range(99);
		if (pick < 36)
			c.command = CMD_ALLOC;
		else if (pick < 56)
			c.command = CMD_FREE;
		else if (pick < 64)
			c.command = CMD_PROTECT;
		else if (pick < 76)
			c.command = CMD_LOAD;
		else if (pick < 86)
			c.command = CMD_READ;
		else if (pick < 93)
			c.command = CMD_SET_COUNT;
		else
			c.command = ($urandom_range(1) == 0) ? CMD_SPARE_A : CMD_SPARE_B;
		return c;
	endfunction

	// The sender pauses here until every expected word has come back.
	task automatic wait_until_drained();
		do
			@(negedge clk);
		while (cmd_words.size() != 0 || cmd_valid || expected_rsp_words.size() != 0);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: extremes, refused frees, saturation and level aging.
		push_cmd(CMD_READ, 10'd0, 4'h0, 8'h00, 11'd0);
		push_cmd(CMD_READ, 10'd1023, 4'hF, 8'hFF, 11'd2047);
		push_cmd(CMD_ALLOC, 10'd0, 4'h0, 8'h00, 11'd0);
		push_cmd(CMD_ALLOC, 10'd1023, 4'hF, 8'hFF, 11'd2047);
		push_cmd(CMD_FREE, 10'd0, 4'h0, 8'h00, 11'd0);
		push_cmd(CMD_FREE, 10'd1, 4'h0, 8'h00, 11'd0);
		push_cmd(CMD_FREE, 10'd2, 4'h0, 8'h00, 11'd0);
		push_cmd(CMD_FREE, 10'd2, 4'h0, 8'h00, 11'd0);
		push_cmd(CMD_FREE, 10'd5, 4'h0, 8'h00, 11'd0);
		push_cmd(CMD_PROTECT, 10'd0, 4'h0, 8'h00, 11'd0);
		push_cmd(CMD_PROTECT, 10'd1023, 4'h0, 8'h00, 11'd0);
		push_cmd(CMD_LOAD, 10'd1023, 4'h0, 8'h00, 11'd0);
		push_cmd(CMD_LOAD, 10'd4, 4'h0, 8'hFF, 11'd0);
		push_cmd(CMD_SET_COUNT, 10'd4, 4'h0, 8'h00, 11'd2047);
		push_cmd(CMD_ALLOC, 10'd0, 4'hA, 8'h00, 11'd0);
		push_cmd(CMD_SET_COUNT, 10'd1023, 4'h0, 8'h00, 11'd1024);
		push_cmd(CMD_SET_COUNT, 10'd0, 4'h0, 8'h00, 11'd0);
		push_cmd(CMD_LOAD, 10'd0, 4'h0, 8'h05, 11'd0);
		push_cmd(CMD_ALLOC, 10'd0, 4'h3, 8'h00, 11'd0);
		push_cmd(CMD_SET_COUNT, 10'd1, 4'h0, 8'h00, 11'd1000);
		push_cmd(CMD_ALLOC, 10'd0, 4'h7, 8'h00, 11'd0);
		push_cmd(CMD_SPARE_A, 10'd3, 4'h0, 8'h00, 11'd0);
		push_cmd(CMD_SPARE_B, 10'd1022, 4'h0, 8'h00, 11'd0);
		push_cmd(CMD_FREE, 10'd1023, 4'h0, 8'h00, 11'd0);
		push_cmd(CMD_READ, 10'd1023, 4'h0, 8'h00, 11'd0);
		wait_until_drained();

		for (int phase = 0; phase < 4; phase++) begin
			idle_mode = idle_mode_t'(phase);
			if (phase == 0) begin
				// Short words back to back while the receiver holds off,
				// so the block backs up and stalls its input.
				repeat (12)
					push_cmd(CMD_READ, 10'($urandom_range(1023)), 4'h0, 8'h00, 11'd0);
				hold_requests++;
			end
			repeat (62)
				cmd_words.push_back(random_command());
			wait_until_drained();
		end

		repeat (50) @(negedge clk);
		if (mismatches == 0 && expected_rsp_words.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

### flash_block_allocator_aging_top.f
+incdir+hdl
hdl/fba_pkg.sv
hdl/flash_block_allocator_aging_top.sv
bench/tb.sv
